>>> src/sbs_pkg.sv
// Shared types, constants and the control store of the beacon scheduler.
// Used by sbs_datapath and smart_beacon_scheduler; depends on nothing else.
package sbs_pkg;

    // Field widths
    localparam int SECS_W  = 16;
    localparam int SPEED_W = 16;
    localparam int HDG_W   = 9;
    localparam int RATE_W  = 16;
    localparam int BAND_W  = 12;
    localparam int TIMER_W = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Divider: 32-bit dividend, one quotient bit per step
    localparam int DIV_W = 32;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

    // Heading arithmetic
    localparam logic [HDG_W-1:0] HALF_TURN = 9'd180;
    localparam logic [HDG_W-1:0] FULL_TURN = 9'd360;
    localparam int CHG_W  = 8;
    localparam int TPROD_W = CHG_W + SPEED_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_SPEED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_RATE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_RATE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SLOPE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_HOLD     = 3'd7;

    typedef struct packed {
        logic [SECS_W-1:0]  elapsed_secs;
        logic               fix_valid;
        logic [SPEED_W-1:0] speed_q4;
        logic [HDG_W-1:0]   heading_deg;
    } t_in_word;

    typedef struct packed {
        logic              send_status;
        logic              send_position;
        logic [RATE_W-1:0] rate_now;
    } t_out_word;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_BEACON,
        OP_STATUS,
        OP_POS,
        OP_BAND,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_RATE,
        OP_TURN,
        OP_OUT
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_NO_IN,
        C_NOT_SMART,
        C_BAND_EDGE,
        C_CNT_NZ,
        C_OUT_BUSY
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic in_load;
    } t_dp_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic not_smart;
        logic band_edge;
        logic cnt_nz;
    } t_dp_flags;

    // Program addresses
    localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] PC_INIT   = 4'd1;
    localparam logic [PC_W-1:0] PC_BEACON = 4'd2;
    localparam logic [PC_W-1:0] PC_STATUS = 4'd3;
    localparam logic [PC_W-1:0] PC_POS    = 4'd4;
    localparam logic [PC_W-1:0] PC_BAND   = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL    = 4'd6;
    localparam logic [PC_W-1:0] PC_DINIT  = 4'd7;
    localparam logic [PC_W-1:0] PC_DSTEP  = 4'd8;
    localparam logic [PC_W-1:0] PC_RATE   = 4'd9;
    localparam logic [PC_W-1:0] PC_TURN   = 4'd10;
    localparam logic [PC_W-1:0] PC_OUT    = 4'd11;
    localparam logic [PC_W-1:0] PC_WRAP   = 4'd12;

    // Control store: one word per step
    function automatic t_uword sbs_uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_JUMP, target: PC_IDLE};
        case (pc)
            PC_IDLE:   w = '{op: OP_NOP,      cond: C_NO_IN,     target: PC_IDLE};
            PC_INIT:   w = '{op: OP_INIT,     cond: C_NEXT,      target: PC_IDLE};
            PC_BEACON: w = '{op: OP_BEACON,   cond: C_NEXT,      target: PC_IDLE};
            PC_STATUS: w = '{op: OP_STATUS,   cond: C_NEXT,      target: PC_IDLE};
            PC_POS:    w = '{op: OP_POS,      cond: C_NOT_SMART, target: PC_OUT};
            PC_BAND:   w = '{op: OP_BAND,     cond: C_BAND_EDGE, target: PC_OUT};
            PC_MUL:    w = '{op: OP_MUL,      cond: C_NEXT,      target: PC_IDLE};
            PC_DINIT:  w = '{op: OP_DIV_INIT, cond: C_NEXT,      target: PC_IDLE};
            PC_DSTEP:  w = '{op: OP_DIV_STEP, cond: C_CNT_NZ,    target: PC_DSTEP};
            PC_RATE:   w = '{op: OP_RATE,     cond: C_NEXT,      target: PC_IDLE};
            PC_TURN:   w = '{op: OP_TURN,     cond: C_NEXT,      target: PC_IDLE};
            PC_OUT:    w = '{op: OP_OUT,      cond: C_OUT_BUSY,  target: PC_OUT};
            PC_WRAP:   w = '{op: OP_NOP,      cond: C_JUMP,      target: PC_IDLE};
            default:   w = '{op: OP_NOP,      cond: C_JUMP,      target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> src/sbs_datapath.sv
// Datapath of the beacon scheduler: configuration registers, timers,
// rate divider and turn test, driven one operation per cycle. Uses sbs_pkg.
module sbs_datapath #(
    parameter int MIN_TURN_ANGLE = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbs_pkg::t_dp_ctl              i_ctl,
    input  sbs_pkg::t_in_word             i_in_word,
    input  logic                          i_cfg_we,
    input  logic [sbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbs_pkg::CFG_W-1:0]     i_cfg_data,
    output sbs_pkg::t_dp_flags            o_flags,
    output sbs_pkg::t_out_word            o_res
);
    import sbs_pkg::*;

    localparam logic [CHG_W-1:0] MIN_ANG = CHG_W'(MIN_TURN_ANGLE);

    // Configuration
    logic [RATE_W-1:0] r_static_rate, r_status_period, r_slow_rate, r_fast_rate;
    logic [RATE_W-1:0] r_turn_slope, r_turn_hold;
    logic [BAND_W-1:0] r_low_speed, r_high_speed;

    // Tick state
    t_in_word           r_in;
    logic [TIMER_W-1:0] r_beacon, r_status;
    logic [RATE_W-1:0]  r_rate;
    logic [HDG_W-1:0]   r_last_hdg;
    logic               r_started, r_st, r_pos;

    // Work registers
    logic [DIV_W-1:0]   r_num;
    logic [SPEED_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_chg_gt;
    logic [CHG_W-1:0]   r_chg_diff;
    logic [TPROD_W-1:0] r_tprod;

    logic                     slow_band, fast_band;
    logic [TIMER_W-1:0]       beacon_sum, status_sum;
    logic [HDG_W-1:0]         hdg_ad;
    logic [CHG_W-1:0]         hdg_chg;
    logic [SPEED_W:0]         div_shift, div_sub;
    logic                     div_bit;
    logic [RATE_W+BAND_W-1:0] rate_prod;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [SECS_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {{(TIMER_W + 1 - SECS_W){1'b0}}, b};
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    // Speed bands
    assign slow_band = r_in.speed_q4 <= {r_low_speed, 4'b0000};
    assign fast_band = r_in.speed_q4 >= {r_high_speed, 4'b0000};

    // Timer sums
    assign beacon_sum = sat_add(r_beacon, r_in.elapsed_secs);
    assign status_sum = sat_add(r_status, r_in.elapsed_secs);

    // Dividend base: fast rate times fast band limit, full width
    assign rate_prod = r_fast_rate * r_high_speed;

    // Heading change, folded onto the short way around
    always_comb begin
        hdg_ad = (r_in.heading_deg >= r_last_hdg) ? r_in.heading_deg - r_last_hdg
                                                  : r_last_hdg - r_in.heading_deg;
        if (hdg_ad <= HALF_TURN) begin
            hdg_chg = hdg_ad[CHG_W-1:0];
        end else if (hdg_ad >= FULL_TURN) begin
            hdg_chg = CHG_W'(hdg_ad - FULL_TURN);
        end else begin
            hdg_chg = CHG_W'(FULL_TURN - hdg_ad);
        end
    end

    // Restoring divide step
    assign div_shift = {r_rem, r_num[DIV_W-1]};
    assign div_sub   = div_shift - {1'b0, r_in.speed_q4};
    assign div_bit   = div_shift >= {1'b0, r_in.speed_q4};

    assign o_flags.not_smart = (r_static_rate != '0) || !r_in.fix_valid;
    assign o_flags.band_edge = slow_band || fast_band;
    assign o_flags.cnt_nz    = r_cnt != '0;

    assign o_res.send_status   = r_st;
    assign o_res.send_position = r_pos;
    assign o_res.rate_now      = r_rate;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_static_rate   <= 16'd0;
            r_status_period <= 16'd0;
            r_low_speed     <= 12'd5;
            r_high_speed    <= 12'd60;
            r_slow_rate     <= 16'd1800;
            r_fast_rate     <= 16'd180;
            r_turn_slope    <= 16'd255;
            r_turn_hold     <= 16'd15;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STATIC_RATE:   r_static_rate   <= i_cfg_data;
                REG_STATUS_PERIOD: r_status_period <= i_cfg_data;
                REG_LOW_SPEED:     r_low_speed     <= i_cfg_data[BAND_W-1:0];
                REG_HIGH_SPEED:    r_high_speed    <= i_cfg_data[BAND_W-1:0];
                REG_SLOW_RATE:     r_slow_rate     <= i_cfg_data;
                REG_FAST_RATE:     r_fast_rate     <= i_cfg_data;
                REG_TURN_SLOPE:    r_turn_slope    <= i_cfg_data;
                REG_TURN_HOLD:     r_turn_hold     <= i_cfg_data;
                default:           r_turn_hold     <= r_turn_hold;
            endcase
        end
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (i_ctl.in_load) begin
            r_in <= i_in_word;
        end
    end

    // Tick state, one operation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beacon   <= '0;
            r_status   <= '0;
            r_rate     <= '0;
            r_last_hdg <= '0;
            r_started  <= 1'b0;
            r_st       <= 1'b0;
            r_pos      <= 1'b0;
            r_cnt      <= '0;
        end else begin
            case (i_ctl.op)
                OP_INIT: begin
                    r_st  <= 1'b0;
                    r_pos <= 1'b0;
                    if (!r_started) begin
                        r_started <= 1'b1;
                        r_rate    <= r_static_rate;
                        r_beacon  <= {{(TIMER_W - RATE_W){1'b0}}, r_static_rate};
                        r_status  <= {{(TIMER_W - RATE_W){1'b0}}, r_status_period};
                    end
                end
                OP_BEACON: begin
                    r_beacon <= beacon_sum;
                end
                OP_STATUS: begin
                    if (r_status_period != '0) begin
                        if (status_sum >= {{(TIMER_W - RATE_W){1'b0}}, r_status_period}) begin
                            r_st     <= 1'b1;
                            r_status <= '0;
                        end else begin
                            r_status <= status_sum;
                        end
                    end
                end
                OP_POS: begin
                    if (r_in.fix_valid &&
                        r_beacon >= {{(TIMER_W - RATE_W){1'b0}}, r_rate}) begin
                        r_pos      <= 1'b1;
                        r_beacon   <= '0;
                        r_last_hdg <= r_in.heading_deg;
                    end
                end
                OP_BAND: begin
                    if (slow_band) begin
                        r_rate <= r_slow_rate;
                    end else if (fast_band) begin
                        r_rate <= r_fast_rate;
                    end
                end
                OP_DIV_INIT: begin
                    r_cnt <= DIV_LAST;
                end
                OP_DIV_STEP: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                OP_RATE: begin
                    r_rate <= (r_num[DIV_W-1:RATE_W] != '0) ? {RATE_W{1'b1}}
                                                            : r_num[RATE_W-1:0];
                end
                OP_TURN: begin
                    if (r_chg_gt &&
                        r_tprod > {{(TPROD_W - RATE_W - 4){1'b0}}, r_turn_slope, 4'b0000} &&
                        r_beacon > {{(TIMER_W - RATE_W){1'b0}}, r_turn_hold}) begin
                        r_beacon <= {{(TIMER_W - RATE_W){1'b0}}, r_rate};
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Work registers: product, divider, turn product
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_MUL: begin
                r_num      <= {rate_prod, 4'b0000};
                r_chg_gt   <= hdg_chg > MIN_ANG;
                r_chg_diff <= hdg_chg - MIN_ANG;
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= div_bit ? div_sub[SPEED_W-1:0] : div_shift[SPEED_W-1:0];
                r_num <= {r_num[DIV_W-2:0], div_bit};
            end
            OP_RATE: begin
                r_tprod <= r_chg_diff * r_in.speed_q4;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

>>> src/smart_beacon_scheduler.sv
// Beacon scheduler top level: control store sequencer, handshakes and result
// register around sbs_datapath. Uses sbs_pkg.
//
// One tick word in gives one result word out. The block runs a small program
// from a control store, one step per cycle bar waits at the output step, and
// takes one tick at a time. A tick with an invalid fix or in static mode
// jumps from the position step to output; a slow or fast band speed passes
// the band step first; one between the bands runs the 32-step restoring
// divider for the beacon period. The result sits in an output register, so
// a new tick is accepted while the previous result still waits to be taken.
module smart_beacon_scheduler #(
    parameter int MIN_TURN_ANGLE = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sbs_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sbs_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [sbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbs_pkg::CFG_W-1:0]     i_cfg_data
);
    import sbs_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid;
    t_out_word       r_out_word;
    t_uword          uw;
    t_dp_ctl         dp_ctl;
    t_dp_flags       dp_flags;
    t_out_word       dp_res;
    logic            in_fire, out_busy, take;

    assign uw         = sbs_uprog(r_pc);
    assign o_in_ready = r_pc == PC_IDLE;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_busy   = r_out_valid && !i_out_ready;

    assign dp_ctl.op      = uw.op;
    assign dp_ctl.in_load = in_fire;

    // Evaluate the jump condition
    always_comb begin
        case (uw.cond)
            C_NEXT:      take = 1'b0;
            C_JUMP:      take = 1'b1;
            C_NO_IN:     take = !in_fire;
            C_NOT_SMART: take = dp_flags.not_smart;
            C_BAND_EDGE: take = dp_flags.band_edge;
            C_CNT_NZ:    take = dp_flags.cnt_nz;
            C_OUT_BUSY:  take = out_busy;
            default:     take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + 1'b1;
    end

    // Advance the sequencer, hold the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (uw.op == OP_OUT && !out_busy) begin
                r_out_valid <= 1'b1;
                r_out_word  <= dp_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    sbs_datapath #(
        .MIN_TURN_ANGLE(MIN_TURN_ANGLE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (dp_ctl),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_flags    (dp_flags),
        .o_res      (dp_res)
    );

endmodule
